// ===== design/cbpd_pkg.sv =====
// Shared types, codes and character tables for the caption byte pair decoder.
package cbpd_pkg;

  typedef enum logic [2:0] {
    EV_CHAR      = 3'd0,
    EV_BACKSPACE = 3'd1,
    EV_PAC       = 3'd2,
    EV_MIDROW    = 3'd3,
    EV_TAB       = 3'd4,
    EV_MISC      = 3'd5,
    EV_TSPACE    = 3'd6
  } event_kind_t;

  localparam logic [7:0]  NULL_BYTE      = 8'h80;
  localparam logic [15:0] BLOCK_GLYPH    = 16'h2588;
  localparam logic [6:0]  FIRST_PRINT    = 7'h20;
  localparam logic [6:0]  TSPACE_CODE    = 7'h39;
  localparam logic [2:0]  TRACK_OFF      = 3'd0;
  localparam logic [2:0]  TRACK_F1_CH1   = 3'd1;
  localparam logic [2:0]  TRACK_F1_CH2   = 3'd2;
  localparam logic [2:0]  TRACK_F2_CH1   = 3'd3;
  localparam logic [2:0]  TRACK_F2_CH2   = 3'd4;
  localparam logic [3:0]  MISC_AOF       = 4'h2;
  localparam logic [3:0]  MISC_AON       = 4'h3;
  localparam logic [3:0]  MISC_TR        = 4'hA;
  localparam logic [3:0]  MISC_RTD       = 4'hB;

  typedef struct packed {
    event_kind_t kind;
    logic [15:0] char_code;
    logic [3:0]  misc_command;
    logic [2:0]  midrow_color;
    logic        midrow_underline;
    logic        midrow_italics;
    logic [6:0]  pac_high;
    logic [6:0]  pac_low;
    logic [1:0]  tab_columns;
    logic        last;
  } event_t;

  // Decoder state that follows the stream (channel 0 = channel one)
  typedef struct packed {
    logic       chan;
    logic       expect_repeat;
    logic [6:0] last_ctrl_high;
    logic [6:0] last_ctrl_low;
  } state_t;

  typedef struct packed {
    event_t [1:0] ev;
    logic [1:0]   count;
    state_t       nxt;
  } decode_t;

  function automatic logic [15:0] special_char(input logic [3:0] idx);
    logic [15:0] c;
    case (idx)
      4'h0: c = 16'h00AE;  4'h1: c = 16'h00B0;  4'h2: c = 16'h00BD;  4'h3: c = 16'h00BF;
      4'h4: c = 16'h2122;  4'h5: c = 16'h00A2;  4'h6: c = 16'h00A3;  4'h7: c = 16'h266A;
      4'h8: c = 16'h00E0;  4'h9: c = 16'h0020;  4'hA: c = 16'h00E8;  4'hB: c = 16'h00E2;
      4'hC: c = 16'h00EA;  4'hD: c = 16'h00EE;  4'hE: c = 16'h00F4;  4'hF: c = 16'h00FB;
      default: c = 16'h0020;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] ext_sfm_char(input logic [4:0] idx);
    logic [15:0] c;
    case (idx)
      5'h00: c = 16'h00C1;  5'h01: c = 16'h00C9;  5'h02: c = 16'h00D3;  5'h03: c = 16'h00DA;
      5'h04: c = 16'h00DC;  5'h05: c = 16'h00FC;  5'h06: c = 16'h2018;  5'h07: c = 16'h00A1;
      5'h08: c = 16'h002A;  5'h09: c = 16'h0027;  5'h0A: c = 16'h2014;  5'h0B: c = 16'h00A9;
      5'h0C: c = 16'h2120;  5'h0D: c = 16'h2022;  5'h0E: c = 16'h201C;  5'h0F: c = 16'h201D;
      5'h10: c = 16'h00C0;  5'h11: c = 16'h00C2;  5'h12: c = 16'h00C7;  5'h13: c = 16'h00C8;
      5'h14: c = 16'h00CA;  5'h15: c = 16'h00CB;  5'h16: c = 16'h00EB;  5'h17: c = 16'h00CE;
      5'h18: c = 16'h00CF;  5'h19: c = 16'h00EF;  5'h1A: c = 16'h00D4;  5'h1B: c = 16'h00D9;
      5'h1C: c = 16'h00F9;  5'h1D: c = 16'h00DB;  5'h1E: c = 16'h00AB;  5'h1F: c = 16'h00BB;
      default: c = 16'h0020;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] ext_pgd_char(input logic [4:0] idx);
    logic [15:0] c;
    case (idx)
      5'h00: c = 16'h00C3;  5'h01: c = 16'h00E3;  5'h02: c = 16'h00CD;  5'h03: c = 16'h00CC;
      5'h04: c = 16'h00EC;  5'h05: c = 16'h00D2;  5'h06: c = 16'h00F2;  5'h07: c = 16'h00D5;
      5'h08: c = 16'h00F5;  5'h09: c = 16'h007B;  5'h0A: c = 16'h007D;  5'h0B: c = 16'h005C;
      5'h0C: c = 16'h005E;  5'h0D: c = 16'h005F;  5'h0E: c = 16'h007C;  5'h0F: c = 16'h007E;
      5'h10: c = 16'h00C4;  5'h11: c = 16'h00E4;  5'h12: c = 16'h00D6;  5'h13: c = 16'h00F6;
      5'h14: c = 16'h00DF;  5'h15: c = 16'h00A5;  5'h16: c = 16'h00A4;  5'h17: c = 16'h007C;
      5'h18: c = 16'h00C5;  5'h19: c = 16'h00E5;  5'h1A: c = 16'h00D8;  5'h1B: c = 16'h00F8;
      5'h1C: c = 16'h231C;  5'h1D: c = 16'h231D;  5'h1E: c = 16'h231E;  5'h1F: c = 16'h231F;
      default: c = 16'h0020;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] printable_char(input logic [6:0] ch);
    logic [15:0] c;
    case (ch)
      7'h27:   c = 16'h2019;
      7'h2A:   c = 16'h00E1;
      7'h5C:   c = 16'h00E9;
      7'h5E:   c = 16'h00ED;
      7'h5F:   c = 16'h00F3;
      7'h60:   c = 16'h00FA;
      7'h7B:   c = 16'h00E7;
      7'h7C:   c = 16'h00F7;
      7'h7D:   c = 16'h00D1;
      7'h7E:   c = 16'h00F1;
      7'h7F:   c = BLOCK_GLYPH;
      default: c = {9'd0, ch};
    endcase
    return c;
  endfunction

endpackage

// ===== design/cbpd_decode.sv =====
// Combinational classification of one byte pair into up to two events.
module cbpd_decode import cbpd_pkg::*; (
  input  logic [7:0] first_byte,
  input  logic [7:0] second_byte,
  input  logic [2:0] caption_track,
  input  state_t     st,
  output decode_t    dec
);

  logic [6:0] a7;
  logic [6:0] b7;
  logic       off;
  logic       want;
  logic       null_pair;
  logic       parity_ok;
  logic       is_pac;
  logic       is_mid;
  logic       is_tab;
  logic       is_misc;
  logic       is_ctrl;
  logic       is_spec;
  logic       is_ext;
  logic       repeat_hit;
  logic       reserved;
  event_t     ev0;
  event_t     ev1;

  assign a7        = first_byte[6:0];
  assign b7        = second_byte[6:0];
  assign off       = !(caption_track inside {[TRACK_F1_CH1:TRACK_F2_CH2]});
  assign want      = (caption_track == TRACK_F1_CH2) || (caption_track == TRACK_F2_CH2);
  assign null_pair = (first_byte == NULL_BYTE) && (second_byte == NULL_BYTE);
  assign parity_ok = (^first_byte) && (^second_byte);

  assign is_pac  = (a7 inside {[7'h10:7'h1F]}) && (b7 >= 7'h40);
  assign is_mid  = (a7 inside {7'h11, 7'h19}) && (b7 inside {[7'h20:7'h2F]});
  assign is_tab  = (a7 inside {7'h17, 7'h1F}) && (b7 inside {[7'h21:7'h23]});
  assign is_misc = (a7 inside {7'h14, 7'h1C}) && (b7 inside {[7'h20:7'h2F]});
  assign is_ctrl = is_pac || is_mid || is_tab || is_misc;
  assign is_spec = (a7 inside {7'h11, 7'h19}) && (b7 inside {[7'h30:7'h3F]});
  assign is_ext  = (a7 inside {7'h12, 7'h13, 7'h1A, 7'h1B}) && (b7 inside {[7'h20:7'h3F]});

  assign repeat_hit = st.expect_repeat && (st.last_ctrl_high == a7) && (st.last_ctrl_low == b7);
  assign reserved   = is_misc && (b7[3:0] inside {MISC_AOF, MISC_AON, MISC_TR, MISC_RTD});

  always_comb begin
    ev0       = '0;
    ev1       = '0;
    dec.count = 2'd0;
    dec.nxt   = st;
    if (!off && !null_pair) begin
      if (!parity_ok) begin
        ev0.kind      = EV_CHAR;
        ev0.char_code = BLOCK_GLYPH;
        ev0.last      = 1'b1;
        dec.count     = 2'd1;
      end else if (is_ctrl) begin
        dec.nxt.chan = a7[3];
        if (a7[3] == want) begin
          if (repeat_hit) begin
            dec.nxt.expect_repeat = 1'b0;
          end else begin
            dec.nxt.expect_repeat  = 1'b1;
            dec.nxt.last_ctrl_high = a7;
            dec.nxt.last_ctrl_low  = b7;
            if (!reserved) begin
              dec.count = 2'd1;
              ev0.last  = 1'b1;
              if (is_pac) begin
                ev0.kind     = EV_PAC;
                ev0.pac_high = a7;
                ev0.pac_low  = b7;
              end else if (is_mid) begin
                ev0.kind             = EV_MIDROW;
                ev0.midrow_underline = b7[0];
                if (b7 >= 7'h2E) begin
                  ev0.midrow_italics = 1'b1;
                end else begin
                  ev0.midrow_color = b7[3:1];
                end
              end else if (is_tab) begin
                ev0.kind        = EV_TAB;
                ev0.tab_columns = b7[1:0];
              end else begin
                ev0.kind         = EV_MISC;
                ev0.misc_command = b7[3:0];
              end
            end
          end
        end
      end else begin
        dec.nxt.expect_repeat = 1'b0;
        if (is_spec) begin
          dec.nxt.chan = a7[3];
          if (a7[3] == want) begin
            dec.count = 2'd1;
            ev0.last  = 1'b1;
            if (b7 == TSPACE_CODE) begin
              ev0.kind = EV_TSPACE;
            end else begin
              ev0.kind      = EV_CHAR;
              ev0.char_code = special_char(b7[3:0]);
            end
          end
        end else if (is_ext) begin
          dec.nxt.chan = a7[3];
          if (a7[3] == want) begin
            dec.count = 2'd2;
            ev0.kind  = EV_BACKSPACE;
            ev1.kind  = EV_CHAR;
            ev1.last  = 1'b1;
            ev1.char_code = a7[0] ? ext_pgd_char(b7[4:0]) : ext_sfm_char(b7[4:0]);
          end
        end else if (st.chan == want) begin
          // Each byte at or above the printable base gives one character
          if ((a7 >= FIRST_PRINT) && (b7 >= FIRST_PRINT)) begin
            dec.count     = 2'd2;
            ev0.char_code = printable_char(a7);
            ev1.char_code = printable_char(b7);
            ev1.last      = 1'b1;
          end else if (a7 >= FIRST_PRINT) begin
            dec.count     = 2'd1;
            ev0.char_code = printable_char(a7);
            ev0.last      = 1'b1;
          end else if (b7 >= FIRST_PRINT) begin
            dec.count     = 2'd1;
            ev0.char_code = printable_char(b7);
            ev0.last      = 1'b1;
          end
        end
      end
    end
    dec.ev[0] = ev0;
    dec.ev[1] = ev1;
  end

endmodule

// ===== design/cbpd_event_buf.sv =====
// Two-entry event queue that holds results until the output side takes them.
module cbpd_event_buf import cbpd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  event_t [1:0] push_ev,
  input  logic [1:0]   push_n,
  input  logic         pop,
  output event_t       head,
  output logic [1:0]   count
);

  event_t [1:0] slot;
  event_t [1:0] slot_next;
  logic [1:0]   count_next;
  logic [1:0]   base;
  logic [1:0]   rel;

  assign base = count - {1'b0, pop};

  always_comb begin
    slot_next    = slot;
    rel          = 2'd0;
    if (pop) begin
      slot_next[0] = slot[1];
    end
    for (int p = 0; p < 2; p++) begin
      rel = 2'(p) - base;
      if (rel < push_n) begin
        slot_next[p] = push_ev[rel[0]];
      end
    end
    count_next = base + push_n;
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  assign head = slot[0];

endmodule

// ===== design/caption_byte_pair_decoder.sv =====
// Top level of the caption byte pair decoder: input register, decode, event queue.
//
//  Channel  Direction  Signals                    Contents (lowest bit first)
//  -------  ---------  -------------------------  --------------------------------------
//  s_axis   in         tvalid tready tdata[15:0]  first_byte, second_byte
//  m_axis   out        tvalid tready tdata[47:0]  char_code, misc_command, midrow_color,
//                      tuser[2:0] tlast           midrow_underline, midrow_italics,
//                                                 pac_high, pac_low, tab_columns, zeros
//  cfg      in         cfg_we cfg_wdata[2:0]      caption_track
//
// A pair is registered on its transaction, decoded in the next cycle and its events
// (none, one or two) are written into a two-entry queue whose head is offered on
// m_axis. One pair per cycle is sustained while m_axis does not stall and
// each pair gives at most one event; a two-event pair (extended character, two
// printable bytes) fills the queue faster than the single output port, which
// passes one event at a time, can drain it.
// Reset clears the queue, the input register, the track (captions off) and the
// channel and repeat state. A stall on m_axis fills the queue, then holds the input
// register, then drops s_axis_tready.
module caption_byte_pair_decoder import cbpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] first_byte, [15:8] second_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] char_code, [19:16] misc_command, [22:20] midrow_color,
  // [23] midrow_underline, [24] midrow_italics, [31:25] pac_high,
  // [38:32] pac_low, [40:39] tab_columns, [47:41] zero
  output logic [47:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // [2:0] event_kind
  output logic        m_axis_tlast,   // last event of the pair
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata       // caption_track
);

  logic [2:0]  caption_track;
  logic        field2;
  state_t      st;
  logic        in_valid;
  logic [15:0] in_pair;
  decode_t     dec;
  event_t      head;
  logic [1:0]  count;
  logic        pop;
  logic        advance;
  logic [1:0]  push_n;
  logic        s_accept;
  logic        cfg_field2;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign pop      = m_axis_tvalid && m_axis_tready;
  // Move the registered pair on only when its events fit beside what the queue keeps
  assign advance  = in_valid &&
                    ((3'(count) - 3'(pop) + 3'(dec.count)) <= 3'd2);
  assign push_n   = advance ? dec.count : 2'd0;
  assign s_axis_tready = !in_valid || advance;

  // Hold the pair until it is decoded
  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_pair <= s_axis_tdata;
    end
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  cbpd_decode u_decode (
    .first_byte    (in_pair[7:0]),
    .second_byte   (in_pair[15:8]),
    .caption_track (caption_track),
    .st            (st),
    .dec           (dec)
  );

  // Field two is selected by tracks three and four; a field change resets the channel
  assign cfg_field2 = (cfg_wdata >= TRACK_F2_CH1);

  always_ff @(posedge clk) begin
    if (rst) begin
      caption_track <= TRACK_OFF;
      field2        <= 1'b0;
      st            <= '0;
    end else if (cfg_we) begin
      caption_track <= cfg_wdata;
      if (cfg_wdata inside {[TRACK_F1_CH1:TRACK_F2_CH2]}) begin
        field2 <= cfg_field2;
        if (cfg_field2 != field2) begin
          st.chan <= 1'b0;
        end
      end
    end else if (advance) begin
      st <= dec.nxt;
    end
  end

  cbpd_event_buf u_event_buf (
    .clk     (clk),
    .rst     (rst),
    .push_ev (dec.ev),
    .push_n  (push_n),
    .pop     (pop),
    .head    (head),
    .count   (count)
  );

  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {7'd0, head.tab_columns, head.pac_low, head.pac_high,
                          head.midrow_italics, head.midrow_underline, head.midrow_color,
                          head.misc_command, head.char_code};

endmodule

// ===== dv/cbpd_tb_pkg.sv =====
`timescale 1ns / 1ps
// Event predictor and scoreboard class for the caption byte pair decoder testbench.
package cbpd_tb_pkg;
  import cbpd_pkg::*;

  localparam logic [15:0] SPECIAL_GLYPHS [16] = '{
    16'h00AE, 16'h00B0, 16'h00BD, 16'h00BF, 16'h2122, 16'h00A2, 16'h00A3, 16'h266A,
    16'h00E0, 16'h0020, 16'h00E8, 16'h00E2, 16'h00EA, 16'h00EE, 16'h00F4, 16'h00FB
  };

  // Spanish, French and miscellaneous extended set
  localparam logic [15:0] SFM_GLYPHS [32] = '{
    16'h00C1, 16'h00C9, 16'h00D3, 16'h00DA, 16'h00DC, 16'h00FC, 16'h2018, 16'h00A1,
    16'h002A, 16'h0027, 16'h2014, 16'h00A9, 16'h2120, 16'h2022, 16'h201C, 16'h201D,
    16'h00C0, 16'h00C2, 16'h00C7, 16'h00C8, 16'h00CA, 16'h00CB, 16'h00EB, 16'h00CE,
    16'h00CF, 16'h00EF, 16'h00D4, 16'h00D9, 16'h00F9, 16'h00DB, 16'h00AB, 16'h00BB
  };

  // Portuguese, German and Danish extended set
  localparam logic [15:0] PGD_GLYPHS [32] = '{
    16'h00C3, 16'h00E3, 16'h00CD, 16'h00CC, 16'h00EC, 16'h00D2, 16'h00F2, 16'h00D5,
    16'h00F5, 16'h007B, 16'h007D, 16'h005C, 16'h005E, 16'h005F, 16'h007C, 16'h007E,
    16'h00C4, 16'h00E4, 16'h00D6, 16'h00F6, 16'h00DF, 16'h00A5, 16'h00A4, 16'h007C,
    16'h00C5, 16'h00E5, 16'h00D8, 16'h00F8, 16'h231C, 16'h231D, 16'h231E, 16'h231F
  };

  class caption_event_ledger;
    logic [2:0] track;
    logic       field_two;
    logic       chan_two;
    logic       repeat_armed;
    logic [6:0] prev_high;
    logic [6:0] prev_low;
    event_t     expected_events[$];
    int         mismatches;

    function new();
      track        = TRACK_OFF;
      field_two    = 1'b0;
      chan_two     = 1'b0;
      repeat_armed = 1'b0;
      prev_high    = '0;
      prev_low     = '0;
      mismatches   = 0;
    endfunction

    // Out-of-range values switch captions off and leave the field alone.
    function void set_track(logic [2:0] value);
      track = value;
      if (value >= TRACK_F1_CH1 && value <= TRACK_F2_CH2) begin
        if ((value >= TRACK_F2_CH1) != field_two) chan_two = 1'b0;
        field_two = (value >= TRACK_F2_CH1);
      end
    endfunction

    function int outstanding();
      return expected_events.size();
    endfunction

    function logic [15:0] plain_glyph(logic [6:0] c);
      case (c)
        7'h27:   return 16'h2019;
        7'h2A:   return 16'h00E1;
        7'h5C:   return 16'h00E9;
        7'h5E:   return 16'h00ED;
        7'h5F:   return 16'h00F3;
        7'h60:   return 16'h00FA;
        7'h7B:   return 16'h00E7;
        7'h7C:   return 16'h00F7;
        7'h7D:   return 16'h00D1;
        7'h7E:   return 16'h00F1;
        7'h7F:   return BLOCK_GLYPH;
        default: return {9'd0, c};
      endcase
    endfunction

    function void push_event(event_kind_t kind, logic [15:0] code, logic last);
      event_t e;
      e           = '0;
      e.kind      = kind;
      e.char_code = code;
      e.last      = last;
      expected_events.insert(expected_events.size(), e);
    endfunction

    function void note_pair(logic [7:0] first_byte, logic [7:0] second_byte);
      logic [6:0] hi;
      logic [6:0] lo;
      logic       want_two;
      logic       is_ctrl;
      logic       ctrl_chan;
      event_t     e;
      hi = first_byte[6:0];
      lo = second_byte[6:0];
      if (track < TRACK_F1_CH1 || track > TRACK_F2_CH2) return;
      want_two = (track == TRACK_F1_CH2 || track == TRACK_F2_CH2);
      if (first_byte == NULL_BYTE && second_byte == NULL_BYTE) return;
      // parity failure: full block glyph whatever the channel, state untouched
      if (!(^first_byte) || !(^second_byte)) begin
        push_event(EV_CHAR, BLOCK_GLYPH, 1'b1);
        return;
      end

      e         = '0;
      e.last    = 1'b1;
      is_ctrl   = 1'b1;
      ctrl_chan = hi[3];
      if (hi >= 7'h10 && hi <= 7'h1F && lo >= 7'h40) begin
        e.kind     = EV_PAC;
        e.pac_high = hi;
        e.pac_low  = lo;
      end else if ((hi == 7'h11 || hi == 7'h19) && lo >= 7'h20 && lo <= 7'h2F) begin
        e.kind             = EV_MIDROW;
        e.midrow_underline = lo[0];
        if (lo >= 7'h2E) e.midrow_italics = 1'b1;
        else e.midrow_color = lo[3:1];
      end else if ((hi == 7'h17 || hi == 7'h1F) && lo >= 7'h21 && lo <= 7'h23) begin
        e.kind        = EV_TAB;
        e.tab_columns = lo[1:0];
      end else if ((hi == 7'h14 || hi == 7'h1C) && lo >= 7'h20 && lo <= 7'h2F) begin
        e.kind         = EV_MISC;
        e.misc_command = lo[3:0];
      end else begin
        is_ctrl = 1'b0;
      end

      if (is_ctrl) begin
        chan_two = ctrl_chan;
        if (chan_two != want_two) return;
        // drop an immediate repeat once
        if (repeat_armed && prev_high == hi && prev_low == lo) begin
          repeat_armed = 1'b0;
          return;
        end
        repeat_armed = 1'b1;
        prev_high    = hi;
        prev_low     = lo;
        // reserved misc codes arm the repeat logic but emit nothing
        if (e.kind == EV_MISC && (e.misc_command == MISC_AOF || e.misc_command == MISC_AON ||
            e.misc_command == MISC_TR || e.misc_command == MISC_RTD)) return;
        expected_events.insert(expected_events.size(), e);
        return;
      end

      repeat_armed = 1'b0;

      if ((hi == 7'h11 || hi == 7'h19) && lo[6:4] == 3'd3) begin
        chan_two = hi[3];
        if (chan_two != want_two) return;
        if (lo == TSPACE_CODE) push_event(EV_TSPACE, 16'h0000, 1'b1);
        else push_event(EV_CHAR, SPECIAL_GLYPHS[lo[3:0]], 1'b1);
        return;
      end

      if ((hi == 7'h12 || hi == 7'h13 || hi == 7'h1A || hi == 7'h1B) &&
          lo >= 7'h20 && lo <= 7'h3F) begin
        chan_two = hi[3];
        if (chan_two != want_two) return;
        push_event(EV_BACKSPACE, 16'h0000, 1'b0);
        push_event(EV_CHAR, hi[0] ? PGD_GLYPHS[lo[4:0]] : SFM_GLYPHS[lo[4:0]], 1'b1);
        return;
      end

      if (chan_two != want_two) return;
      if (hi >= FIRST_PRINT) push_event(EV_CHAR, plain_glyph(hi), lo < FIRST_PRINT);
      if (lo >= FIRST_PRINT) push_event(EV_CHAR, plain_glyph(lo), 1'b1);
    endfunction

    function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_event(event_kind_t kind, logic [47:0] data, logic last);
      event_t want;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event, expected none actual kind %0d data %h last %b",
                 $time, kind, data, last);
        mismatches++;
        return;
      end
      want = expected_events.pop_front();
      compare_field("event_kind", 16'(want.kind), 16'(kind));
      compare_field("char_code", want.char_code, data[15:0]);
      compare_field("misc_command", 16'(want.misc_command), 16'(data[19:16]));
      compare_field("midrow_color", 16'(want.midrow_color), 16'(data[22:20]));
      compare_field("midrow_underline", 16'(want.midrow_underline), 16'(data[23]));
      compare_field("midrow_italics", 16'(want.midrow_italics), 16'(data[24]));
      compare_field("pac_high", 16'(want.pac_high), 16'(data[31:25]));
      compare_field("pac_low", 16'(want.pac_low), 16'(data[38:32]));
      compare_field("tab_columns", 16'(want.tab_columns), 16'(data[40:39]));
      compare_field("tdata padding", 16'h0000, 16'(data[47:41]));
      compare_field("last", 16'(want.last), 16'(last));
    endfunction
  endclass

endpackage

// ===== dv/tb_caption_byte_pair_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for caption_byte_pair_decoder: directed pairs, then random streams.
module tb_caption_byte_pair_decoder;
  import cbpd_pkg::*;
  import cbpd_tb_pkg::*;

  // Nothing accepted on either side for this long means the block has hung.
  localparam int QUIET_LIMIT   = 2000;
  // Let the input register and the event queue settle before touching the register.
  localparam int SETTLE_CYCLES = 6;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [7:0] first_byte, [15:8] second_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // char_code .. tab_columns, zero padding on top
  logic [2:0]  m_axis_tuser;         // event_kind
  logic        m_axis_tlast;
  logic        cfg_we        = 1'b0;
  logic [2:0]  cfg_wdata     = '0;

  int idle_pct     = 0;   // chance in percent that either side starts an idle burst
  int rx_hold      = 0;
  int quiet_cycles = 0;

  caption_event_ledger ledger;

  always #4 clk = ~clk;

  caption_byte_pair_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  // Receiver: hold tready low for bursts of random length while idling is on.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b1;
      rx_hold       <= 0;
    end else if (rx_hold != 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= (rx_hold == 1);
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      rx_hold       <= $urandom_range(1, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check every output transaction against the oldest predicted event.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      ledger.check_event(event_kind_t'(m_axis_tuser), m_axis_tdata, m_axis_tlast);
  end

  // Watchdog: count cycles with no transaction on either stream.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Set bit 7 so the byte carries odd parity.
  function automatic logic [7:0] with_parity(logic [6:0] v);
    return {~^v, v};
  endfunction

  // Offer one pair, possibly after an idle burst, and hold it until the transaction.
  task automatic send_pair(input logic [7:0] first_byte, input logic [7:0] second_byte);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {second_byte, first_byte};
    do @(posedge clk); while (!s_axis_tready);
    ledger.note_pair(first_byte, second_byte);
  endtask

  task automatic send_coded(input logic [6:0] hi, input logic [6:0] lo);
    send_pair(with_parity(hi), with_parity(lo));
  endtask

  // Stop sending and wait until every predicted event has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write caption_track only once the block has gone quiet.
  task automatic write_track(input logic [2:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ledger.set_track(value);
  endtask

  // One random stimulus step: mostly well-formed codes on either channel, some
  // immediate repeats of control codes, plus raw noise and null pairs.
  task automatic send_random_item(inout int sent);
    logic [6:0]  hi;
    logic [6:0]  lo;
    logic [31:0] raw;
    logic        ch;
    int          pick;
    int          copies;
    pick   = $urandom_range(99);
    ch     = 1'($urandom_range(1));
    copies = 1;
    hi     = 7'($urandom_range(32, 127));
    lo     = 7'($urandom_range(127));
    if (pick < 30) begin
      // printable pair as drawn above
    end else if (pick < 44) begin
      hi = 7'h10 + 7'($urandom_range(15));
      lo = 7'($urandom_range(64, 127));
    end else if (pick < 50) begin
      hi = ch ? 7'h19 : 7'h11;
      lo = 7'($urandom_range(32, 47));
    end else if (pick < 55) begin
      hi = ch ? 7'h1F : 7'h17;
      lo = 7'($urandom_range(33, 35));
    end else if (pick < 64) begin
      hi = ch ? 7'h1C : 7'h14;
      lo = 7'($urandom_range(32, 47));
    end else if (pick < 72) begin
      hi = ch ? 7'h19 : 7'h11;
      lo = 7'($urandom_range(48, 63));
    end else if (pick < 80) begin
      hi = (ch ? 7'h1A : 7'h12) | 7'($urandom_range(1));
      lo = 7'($urandom_range(32, 63));
    end else if (pick < 85) begin
      hi = 7'($urandom_range(31));
    end
    // control codes are sometimes sent two or three times in a row
    if (pick >= 30 && pick < 64 && $urandom_range(99) < 40)
      copies = ($urandom_range(3) == 0) ? 3 : 2;

    if (pick >= 85 && pick < 95) begin
      raw = $urandom;
      send_pair(raw[7:0], raw[15:8]);
      sent++;
    end else if (pick >= 95) begin
      send_pair(NULL_BYTE, NULL_BYTE);
    end else begin
      repeat (copies) begin
        send_coded(hi, lo);
        sent++;
      end
    end
  endtask

  logic [2:0] phase_tracks [8] = '{
    TRACK_F1_CH1, TRACK_F2_CH2, TRACK_OFF, TRACK_F1_CH2,
    TRACK_F2_CH1, 3'd5, TRACK_F2_CH2, TRACK_F1_CH1
  };

  initial begin
    int sent;
    int quota;
    ledger = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 20;

    // Captions off after reset: ignore the pair.
    send_coded(7'h41, 7'h42);
    write_track(TRACK_F1_CH1);
    send_pair(NULL_BYTE, NULL_BYTE);
    send_pair(8'h00, 8'hFF);             // both bytes fail parity
    send_coded(7'h7F, 7'h20);            // printable extremes
    send_coded(7'h27, 7'h05);            // only the first byte prints
    send_coded(7'h01, 7'h1F);            // neither byte prints
    send_coded(7'h10, 7'h40);            // PAC, lowest codes
    send_coded(7'h17, 7'h7F);            // PAC, highest channel-one codes
    repeat (3) send_coded(7'h14, 7'h20); // repeat dropped once, third one passes
    send_coded(7'h11, 7'h21);            // mid-row colour with underline
    send_coded(7'h11, 7'h2E);            // mid-row italics
    send_coded(7'h17, 7'h23);            // tab by three columns
    repeat (2) send_coded(7'h14, 7'h22); // reserved misc code, then its repeat
    send_coded(7'h14, 7'h21);            // misc backspace
    send_coded(7'h11, 7'h30);
    send_coded(7'h11, 7'h39);            // transparent space
    send_coded(7'h12, 7'h20);            // extended, first set
    send_coded(7'h13, 7'h3F);            // extended, second set
    send_coded(7'h1B, 7'h25);            // extended on channel two: switch, no event
    send_coded(7'h41, 7'h42);            // wrong channel now
    send_coded(7'h14, 7'h2C);            // back to channel one

    write_track(TRACK_F1_CH2);
    send_coded(7'h1B, 7'h3F);
    send_coded(7'h7E, 7'h60);
    send_coded(7'h1F, 7'h21);
    write_track(TRACK_F2_CH2);           // field change: back on channel one
    send_coded(7'h43, 7'h44);
    send_coded(7'h1C, 7'h2F);
    write_track(3'd7);                   // out of range acts as off
    send_coded(7'h45, 7'h46);
    write_track(TRACK_OFF);
    write_track(TRACK_F2_CH2);           // same field after off: channel kept
    send_coded(7'h47, 7'h48);

    // Random streams under several track settings; the fourth and last phases run flat out.
    for (int p = 0; p < 8; p++) begin
      write_track(phase_tracks[p]);
      idle_pct = (p == 3 || p == 7) ? 0 : $urandom_range(5, 40);
      quota    = (phase_tracks[p] < TRACK_F1_CH1 || phase_tracks[p] > TRACK_F2_CH2) ? 16 : 230;
      sent     = 0;
      while (sent < quota) begin
        send_random_item(sent);
        if ($urandom_range(149) == 0) drain();
      end
    end

    drain();
    if (ledger.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
